@@ rtl/mbx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_pkg
// Shared types and constants of the monochrome bitmap pixel expander.
// ----------------------------------------------------------------------------
package mbx_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_FG      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BG      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 3'd5;

  // field widths
  localparam int COLOR_W = 16;
  localparam int DIM_W   = 9;
  localparam int SCALE_W = 4;
  localparam int ROW_W   = 8;
  localparam int PASS_W  = 3;
  localparam int MAX_HEIGHT = 256;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  // clamped geometry, as seen by front and back
  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
  } mbx_geom_t;

  // one classified item, ready for expansion
  typedef struct packed {
    logic [7:0] value;
    logic [2:0] nbits_m1;
    logic       last_bmp;
    logic       replay;
    logic       wrong;
  } mbx_desc_t;

endpackage

@@ rtl/mbx_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_queue
// Short first-in first-out queue of item descriptors between front and back.
// ----------------------------------------------------------------------------
module mbx_queue import mbx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  mbx_desc_t push_desc,
  output logic      pop_valid,
  input  logic      pop_ready,
  output mbx_desc_t pop_desc
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  mbx_desc_t          slots [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_desc   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/mbx_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_front
// Accepts requests, checks their kind, tracks row/pass position, keeps the
// row buffer and hands one descriptor per request to the queue.
// ----------------------------------------------------------------------------
module mbx_front import mbx_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  mbx_geom_t geom,
  input  logic      restart,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      req_type,
  input  logic [7:0] source_byte,
  output logic      q_valid,
  input  logic      q_ready,
  output mbx_desc_t q_desc
);

  localparam int ROW_BYTES = (MAX_WIDTH + 7) / 8;
  localparam int BP_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int SUM_W     = DIM_W + 1;

  // row buffer, undefined until written
  logic [7:0]        row_store [ROW_BYTES];
  logic [7:0]        rd_data;

  // position state
  logic [BP_W-1:0]   byte_position;
  logic [ROW_W-1:0]  row_position;
  logic [PASS_W-1:0] pass_position;
  logic              replaying;

  // request held while the row buffer read completes
  logic              pend_valid;
  logic              pend_kind;
  logic [7:0]        pend_src;
  logic [2:0]        pend_nbits_m1;
  logic              pend_last_bmp;
  logic              pend_replay;
  logic              pend_wrong;

  logic              accept;
  logic              wrong;
  logic [SUM_W-1:0]  bytes;
  logic              last_byte;
  logic              last_pass;
  logic              last_row;
  logic [PASS_W-1:0] pass_next;
  logic [2:0]        nbits_m1;

  assign replaying = (pass_position != '0);
  assign accept    = in_valid && in_ready;
  assign in_ready  = !pend_valid || q_ready;
  assign wrong     = (req_type != replaying);

  // row geometry for the current byte
  always_comb begin
    bytes     = (SUM_W'(geom.width) + SUM_W'(7)) >> 3;
    last_byte = (SUM_W'(byte_position) + SUM_W'(1)) == bytes;
    last_pass = (SCALE_W'(pass_position) + SCALE_W'(1)) >= geom.sy;
    last_row  = (DIM_W'(row_position) + DIM_W'(1)) >= geom.height;
    pass_next = last_pass ? '0 : pass_position + 1'b1;
    if (last_byte && (geom.width[2:0] != 3'd0)) begin
      nbits_m1 = geom.width[2:0] - 3'd1;
    end else begin
      nbits_m1 = 3'd7;
    end
  end

  // row buffer write on loads, registered read for replays
  always_ff @(posedge clk) begin
    if (accept && !wrong && !req_type) begin
      row_store[byte_position] <= source_byte;
    end
    if (accept) begin
      rd_data <= row_store[byte_position];
    end
  end

  // position tracking
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      byte_position <= '0;
      row_position  <= '0;
      pass_position <= '0;
    end else if (accept && !wrong) begin
      if (last_byte) begin
        byte_position <= '0;
        pass_position <= pass_next;
        if (last_pass) begin
          row_position <= last_row ? '0 : row_position + 1'b1;
        end
      end else begin
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  // pending request control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (q_ready) begin
      pend_valid <= 1'b0;
    end
  end

  // pending request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_kind     <= req_type;
      pend_src      <= source_byte;
      pend_nbits_m1 <= nbits_m1;
      pend_wrong    <= wrong;
      pend_last_bmp <= last_byte && last_pass && last_row;
      pend_replay   <= wrong ? replaying : (last_byte ? (pass_next != '0) : replaying);
    end
  end

  // descriptor toward the queue
  always_comb begin
    q_valid           = pend_valid;
    q_desc.value      = pend_kind ? rd_data : pend_src;
    q_desc.nbits_m1   = pend_nbits_m1;
    q_desc.last_bmp   = pend_last_bmp;
    q_desc.replay     = pend_replay;
    q_desc.wrong      = pend_wrong;
  end

endmodule

@@ rtl/mbx_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_back
// Expands each descriptor into scaled RGB565 pixels, one per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module mbx_back import mbx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [COLOR_W-1:0] color_fg,
  input  logic [COLOR_W-1:0] color_bg,
  input  logic [SCALE_W-1:0] sx,
  input  logic               q_valid,
  output logic               q_ready,
  input  mbx_desc_t          q_desc,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] pixel_color,
  output logic               last_of_item,
  output logic               last_of_bitmap,
  output logic               replay_pending,
  output logic               wrong_kind
);

  // descriptor being expanded
  logic       active;
  logic [7:0] shift_bits;
  logic [2:0] bit_idx;
  logic [2:0] rep_idx;
  logic [2:0] nbits_m1;
  logic       last_bmp;
  logic       replay;
  logic       wrong;

  logic [2:0] sx_m1;
  logic       emit;
  logic       px_last;
  logic       load;

  assign sx_m1   = 3'(sx - 4'd1);
  assign emit    = active && (!out_valid || out_ready);
  assign px_last = wrong || ((bit_idx == nbits_m1) && (rep_idx == sx_m1));
  assign load    = q_valid && (!active || (emit && px_last));
  assign q_ready = !active || (emit && px_last);

  // expansion control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (emit && px_last) begin
      active <= 1'b0;
    end
  end

  // descriptor fields and bit/repeat counters
  always_ff @(posedge clk) begin
    if (load) begin
      shift_bits <= q_desc.value;
      nbits_m1   <= q_desc.nbits_m1;
      last_bmp   <= q_desc.last_bmp;
      replay     <= q_desc.replay;
      wrong      <= q_desc.wrong;
      bit_idx    <= '0;
      rep_idx    <= '0;
    end else if (emit) begin
      if (rep_idx == sx_m1) begin
        rep_idx    <= '0;
        bit_idx    <= bit_idx + 1'b1;
        shift_bits <= {shift_bits[6:0], 1'b0};
      end else begin
        rep_idx <= rep_idx + 1'b1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_color    <= wrong ? '0 : (shift_bits[7] ? color_fg : color_bg);
      last_of_item   <= !wrong && px_last;
      last_of_bitmap <= !wrong && px_last && last_bmp;
      replay_pending <= replay;
      wrong_kind     <= wrong;
    end
  end

endmodule

@@ rtl/mono_bitmap_scaled_pixel_expander_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitmap_scaled_pixel_expander_unit
// Expands a 1 bit per pixel bitmap into scaled RGB565 pixels.
// ----------------------------------------------------------------------------
// A load request brings one packed source byte (leftmost pixel in bit 7) and
// gives nbits*scale_x pixels, where nbits is 8 except on the last byte of a
// row; replay requests re-emit the stored row for passes 2..scale_y. A
// request of the wrong kind gives a single result flagged wrong_kind. The
// pixel expander emits one pixel per cycle while the output is not stalled,
// and the front takes a new request each cycle while its two-entry
// descriptor queue has room; a request passes through the front's pending
// register, the queue and the expander's descriptor registers before its
// first pixel reaches the output register. Writing the width, height or a
// scale register restarts the bitmap; color writes apply at once. The
// configuration port is always ready and must be written only while idle.
// ----------------------------------------------------------------------------
module mono_bitmap_scaled_pixel_expander_unit import mbx_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_SCALE = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [7:0]           source_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COLOR_W-1:0]   pixel_color,
  output logic                 last_of_item,
  output logic                 last_of_bitmap,
  output logic                 replay_pending,
  output logic                 wrong_kind
);

  // configuration registers
  logic [COLOR_W-1:0] color_fg;
  logic [COLOR_W-1:0] color_bg;
  logic [DIM_W-1:0]   bitmap_width;
  logic [DIM_W-1:0]   bitmap_height;
  logic [SCALE_W-1:0] scale_x;
  logic [SCALE_W-1:0] scale_y;
  logic               restart;

  mbx_geom_t geom;
  logic      q_valid;
  logic      q_ready;
  mbx_desc_t q_desc;
  logic      b_valid;
  logic      b_ready;
  mbx_desc_t b_desc;

  assign cfg_ready = 1'b1;

  // geometry writes restart the bitmap on the same edge
  assign restart = cfg_valid && cfg_ready &&
                   (cfg_index inside {REG_BITMAP_WIDTH, REG_BITMAP_HEIGHT,
                                      REG_SCALE_X, REG_SCALE_Y});

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      color_fg      <= 16'hFFFF;
      color_bg      <= '0;
      bitmap_width  <= DIM_W'(8);
      bitmap_height <= DIM_W'(8);
      scale_x       <= SCALE_W'(1);
      scale_y       <= SCALE_W'(1);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_COLOR_FG:      color_fg <= cfg_data;
          REG_COLOR_BG:      color_bg <= cfg_data;
          REG_BITMAP_WIDTH:  bitmap_width <= cfg_data[DIM_W-1:0];
          REG_BITMAP_HEIGHT: bitmap_height <= cfg_data[DIM_W-1:0];
          REG_SCALE_X:       scale_x <= cfg_data[SCALE_W-1:0];
          REG_SCALE_Y:       scale_y <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // geometry clamped to its legal range
  always_comb begin
    if (bitmap_width == '0) begin
      geom.width = DIM_W'(1);
    end else if (32'(bitmap_width) > MAX_WIDTH) begin
      geom.width = DIM_W'(MAX_WIDTH);
    end else begin
      geom.width = bitmap_width;
    end
    if (bitmap_height == '0) begin
      geom.height = DIM_W'(1);
    end else if (32'(bitmap_height) > MAX_HEIGHT) begin
      geom.height = DIM_W'(MAX_HEIGHT);
    end else begin
      geom.height = bitmap_height;
    end
    if (scale_x == '0) begin
      geom.sx = SCALE_W'(1);
    end else if (32'(scale_x) > MAX_SCALE) begin
      geom.sx = SCALE_W'(MAX_SCALE);
    end else begin
      geom.sx = scale_x;
    end
    if (scale_y == '0) begin
      geom.sy = SCALE_W'(1);
    end else if (32'(scale_y) > MAX_SCALE) begin
      geom.sy = SCALE_W'(MAX_SCALE);
    end else begin
      geom.sy = scale_y;
    end
  end

  mbx_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .restart     (restart),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .source_byte (source_byte),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_desc      (q_desc)
  );

  mbx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_valid),
    .push_ready (q_ready),
    .push_desc  (q_desc),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_desc   (b_desc)
  );

  mbx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .color_fg       (color_fg),
    .color_bg       (color_bg),
    .sx             (geom.sx),
    .q_valid        (b_valid),
    .q_ready        (b_ready),
    .q_desc         (b_desc),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_color    (pixel_color),
    .last_of_item   (last_of_item),
    .last_of_bitmap (last_of_bitmap),
    .replay_pending (replay_pending),
    .wrong_kind     (wrong_kind)
  );

endmodule
